@@ rtl/core/lkvc_pkg.sv @@
// shared types, constants and helpers for the lru key-value cache
package lkvc_pkg;

   // storage geometry
   localparam int MAX_ENTRIES = 16;
   localparam int KEY_BITS    = 64;
   localparam int VALUE_BITS  = 32;

   // field widths fixed by the interface
   localparam int CAP_BITS   = 5;
   localparam int KEY_W      = 64;
   localparam int VAL_W      = 32;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   // operation codes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   // request beat
   typedef struct packed {
      logic                    mode;
      logic [KEY_W-1:0]        key;
      logic signed [VAL_W-1:0] write_value;
   } lkvc_req_type;

   // response beat
   typedef struct packed {
      logic                    hit;
      logic signed [VAL_W-1:0] read_value;
      logic                    mru_valid;
      logic [KEY_W-1:0]        mru_key;
   } lkvc_rsp_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic shift;   // take the left neighbor's entry
      logic write;   // overwrite the value in place
      logic trim;    // capacity write: drop the entry if beyond capacity
      logic allow;   // cell position lies below the capacity
   } lkvc_cell_ctl_type;

   // zero means one, anything above the depth saturates
   function automatic logic [CAP_BITS-1:0] lkvc_clamp_cap(input logic [CAP_BITS-1:0] raw);
      logic [CAP_BITS-1:0] c;
      c = raw;
      if (c == '0) begin
         c = CAP_BITS'(1);
      end
      if (32'(c) > MAX_ENTRIES) begin
         c = CAP_BITS'(MAX_ENTRIES);
      end
      return c;
   endfunction

endpackage

@@ rtl/core/lru_key_value_cache.sv @@
// lru key-value cache top level: sequencer, cell chain and response register
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/ready   | lkvc_req_type (mode, key, write_value)
//  rsp     | out       | rsp_valid/ready   | lkvc_rsp_type (hit, read_value, mru_*)
//  csr     | in        | csr_we            | csr_wdata (capacity)
//
// each item first compares the key against every cell, then shifts the chain
// the next item is taken in the shift cycle, overlapping the last one's shift
// a stalled response holds the shift cycle until the response register frees
// synchronous reset empties every cell and sets capacity to 16
module lru_key_value_cache
   import lkvc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lkvc_req_type        req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lkvc_rsp_type        rsp_data,
   input  logic                csr_we,
   input  logic [CAP_BITS-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_MATCH  = 3'b010,
      ST_UPDATE = 3'b100
   } lkvc_state_type;

   lkvc_state_type state_ff, state_in;

   lkvc_req_type            req_ff;
   logic [CAP_BITS-1:0]     cap_ff, cap_in, cap_sel;
   logic [MAX_ENTRIES-1:0]  shift_ff, shift_in;
   logic [MAX_ENTRIES-1:0]  write_ff, write_in;
   logic                    hit_ff, hit_in;
   logic [KEY_BITS-1:0]     hit_key_ff, hit_key_in;
   logic [VALUE_BITS-1:0]   hit_value_ff, hit_value_in;
   logic                    rsp_valid_ff;
   lkvc_rsp_type            rsp_data_ff, rsp_data_in;

   logic                    req_fire, update_fire, slot_free;
   logic [KEY_BITS-1:0]     probe_key;
   logic [VALUE_BITS-1:0]   store_value;
   logic [KEY_BITS-1:0]     head_key;
   logic [VALUE_BITS-1:0]   head_value;
   logic [MAX_ENTRIES-1:0]  match_w;
   logic [MAX_ENTRIES-1:0]  valid_vec;
   logic                    insert_miss;

   logic [KEY_BITS-1:0]     cell_key   [MAX_ENTRIES];
   logic [VALUE_BITS-1:0]   cell_value [MAX_ENTRIES];
   logic [KEY_BITS-1:0]     left_key   [MAX_ENTRIES];
   logic [VALUE_BITS-1:0]   left_value [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]  left_valid;
   lkvc_cell_ctl_type       cell_ctl   [MAX_ENTRIES];

   // handshakes
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign update_fire = (state_ff == ST_UPDATE) && slot_free;
   assign req_ready   = (state_ff == ST_IDLE) || update_fire;
   assign req_fire    = req_valid && req_ready;

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (update_fire) begin
               state_in = req_fire ? ST_MATCH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // capacity register
   assign cap_sel = csr_we ? lkvc_clamp_cap(csr_wdata) : cap_ff;
   assign cap_in  = cap_sel;

   // request fields as stored
   assign probe_key   = req_ff.key[KEY_BITS-1:0];
   assign store_value = VALUE_BITS'(req_ff.write_value);

   // compare cycle: hit vector, shift span and hit entry
   always_comb begin
      insert_miss  = (req_ff.mode == MODE_INSERT) && (match_w == '0);
      hit_in       = (match_w != '0);
      hit_key_in   = '0;
      hit_value_in = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         shift_in[i] = insert_miss ||
                       ((req_ff.mode == MODE_LOOKUP) && ((match_w >> i) != '0));
         write_in[i] = match_w[i] && (req_ff.mode == MODE_INSERT);
         hit_key_in   = hit_key_in   | (match_w[i] ? cell_key[i]   : '0);
         hit_value_in = hit_value_in | (match_w[i] ? cell_value[i] : '0);
      end
   end

   // entry placed at the head of the chain
   assign head_key   = (req_ff.mode == MODE_INSERT) ? probe_key   : hit_key_ff;
   assign head_value = (req_ff.mode == MODE_INSERT) ? store_value : hit_value_ff;

   // cell chain
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign left_key[g]   = head_key;
         assign left_value[g] = head_value;
         assign left_valid[g] = 1'b1;
      end else begin : g_body
         assign left_key[g]   = cell_key[g-1];
         assign left_value[g] = cell_value[g-1];
         assign left_valid[g] = valid_vec[g-1];
      end

      assign cell_ctl[g].shift = update_fire && shift_ff[g];
      assign cell_ctl[g].write = update_fire && write_ff[g];
      assign cell_ctl[g].trim  = csr_we;
      assign cell_ctl[g].allow = 32'(g) < 32'(cap_sel);

      lkvc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[g]),
         .left_key   (left_key[g]),
         .left_value (left_value[g]),
         .left_valid (left_valid[g]),
         .wr_value   (store_value),
         .probe_key  (probe_key),
         .key        (cell_key[g]),
         .value      (cell_value[g]),
         .valid      (valid_vec[g]),
         .match      (match_w[g])
      );
   end

   // response beat, taken from the head after the shift
   always_comb begin
      rsp_data_in.hit        = hit_ff;
      rsp_data_in.read_value = ((req_ff.mode == MODE_LOOKUP) && hit_ff) ?
                               VAL_W'(hit_value_ff) : '0;
      rsp_data_in.mru_valid  = shift_ff[0] || valid_vec[0];
      if (shift_ff[0]) begin
         rsp_data_in.mru_key = KEY_W'(head_key);
      end else if (valid_vec[0]) begin
         rsp_data_in.mru_key = KEY_W'(cell_key[0]);
      end else begin
         rsp_data_in.mru_key = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cap_ff   <= cap_in;
         if (update_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_MATCH) begin
         shift_ff     <= shift_in;
         write_ff     <= write_in;
         hit_ff       <= hit_in;
         hit_key_ff   <= hit_key_in;
         hit_value_ff <= hit_value_in;
      end
      if (update_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // occupied cells always form a prefix of the chain
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + MAX_ENTRIES'(1))) == '0)
      else $error("cell valid bits are not a prefix");

   // never more entries than the capacity allows
   a_within_cap: assert property (@(posedge clock) disable iff (reset)
      32'($countones(valid_vec)) <= 32'(cap_ff))
      else $error("entry count exceeds capacity");

   // keys held are unique, so at most one cell matches
   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MATCH) |-> $onehot0(match_w))
      else $error("more than one cell matched the key");

   // a shift cycle always leaves a response behind
   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      update_fire |=> rsp_valid_ff)
      else $error("response lost after update");
`endif

endmodule

@@ rtl/core/lkvc_cell.sv @@
// one recency slot: key, value and valid, shifting from its left neighbor
module lkvc_cell
   import lkvc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  lkvc_cell_ctl_type     ctl,
   input  logic [KEY_BITS-1:0]   left_key,
   input  logic [VALUE_BITS-1:0] left_value,
   input  logic                  left_valid,
   input  logic [VALUE_BITS-1:0] wr_value,
   input  logic [KEY_BITS-1:0]   probe_key,
   output logic [KEY_BITS-1:0]   key,
   output logic [VALUE_BITS-1:0] value,
   output logic                  valid,
   output logic                  match
);

   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  valid_ff, valid_in;

   // next entry
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.trim) begin
         valid_in = valid_ff & ctl.allow;
      end else if (ctl.shift) begin
         key_in   = left_key;
         value_in = left_value;
         valid_in = left_valid & ctl.allow;
      end else if (ctl.write) begin
         value_in = wr_value;
      end
   end

   // valid is control, key and value are payload
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   // associative compare
   assign match = valid_ff && (key_ff == probe_key);
   assign key   = key_ff;
   assign value = value_ff;
   assign valid = valid_ff;

endmodule
